// ===== design/ivs_pkg.sv =====
// Shared types and constants of the indexed vector store.
package ivs_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int WORD_BITS_DEF = 32;
    localparam int IDX_W         = 6;

    typedef enum logic [3:0] {
        OP_APPEND   = 4'd0,
        OP_INSERT   = 4'd1,
        OP_REMOVE   = 4'd2,
        OP_READ     = 4'd3,
        OP_CLEAR    = 4'd4,
        OP_INC_ALL  = 4'd5,
        OP_DEC_ALL  = 4'd6,
        OP_EMIT_ADD = 4'd7,
        OP_EMIT_SUB = 4'd8,
        OP_EMIT_MUL = 4'd9,
        OP_ADD_AT   = 4'd10,
        OP_SUB_AT   = 4'd11,
        OP_MUL_AT   = 4'd12
    } opcode_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_RANGE = 2'd1,
        STS_FULL  = 2'd2,
        STS_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_LOAD,
        CELL_INC,
        CELL_DEC
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] addr;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } alu_op_t;

endpackage

// ===== design/ivs_cell.sv =====
// One storage cell of the vector chain.
module ivs_cell #(
    parameter int WORD_BITS = ivs_pkg::WORD_BITS_DEF,
    parameter int POS       = 0
) (
    input  logic                  clk,
    input  ivs_pkg::cell_cmd_t    cmd,
    input  logic [WORD_BITS-1:0]  data,
    input  logic [WORD_BITS-1:0]  prev_word,
    input  logic [WORD_BITS-1:0]  next_word,
    output logic [WORD_BITS-1:0]  word
);
    import ivs_pkg::*;

    localparam logic [IDX_W-1:0] POS_V = IDX_W'(POS);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
                word_next = word_reg;
            end
            CELL_SHIFT_UP:
            begin
                if (POS_V > cmd.addr)
                begin
                    word_next = prev_word;
                end
                else if (POS_V == cmd.addr)
                begin
                    word_next = data;
                end
            end
            CELL_SHIFT_DOWN:
            begin
                if (POS_V >= cmd.addr)
                begin
                    word_next = next_word;
                end
            end
            CELL_LOAD:
            begin
                if (POS_V == cmd.addr)
                begin
                    word_next = data;
                end
            end
            CELL_INC:
            begin
                word_next = word_reg + WORD_BITS'(1);
            end
            CELL_DEC:
            begin
                word_next = word_reg - WORD_BITS'(1);
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== design/ivs_alu.sv =====
// Two-stage add, subtract and split-multiply unit.
module ivs_alu #(
    parameter int WORD_BITS = ivs_pkg::WORD_BITS_DEF
) (
    input  logic                  clk,
    input  ivs_pkg::alu_op_t      op,
    input  logic [WORD_BITS-1:0]  a,
    input  logic [WORD_BITS-1:0]  b,
    output logic [WORD_BITS-1:0]  result
);
    import ivs_pkg::*;

    localparam int H = (WORD_BITS + 1) / 2;
    localparam int L = WORD_BITS - H;

    logic [H-1:0]         a_lo;
    logic [H-1:0]         b_lo;
    logic [L-1:0]         a_hi;
    logic [L-1:0]         b_hi;
    logic [2*H-1:0]       ll_next;
    logic [WORD_BITS-1:0] lh_prod;
    logic [WORD_BITS-1:0] hl_prod;
    logic [L-1:0]         cross_next;
    logic [WORD_BITS-1:0] sum_next;

    alu_op_t              op_reg;
    logic [WORD_BITS-1:0] sum_reg;
    logic [2*H-1:0]       ll_reg;
    logic [L-1:0]         cross_reg;
    logic [WORD_BITS-1:0] result_reg;
    logic [WORD_BITS-1:0] result_next;

    assign a_lo       = a[H-1:0];
    assign b_lo       = b[H-1:0];
    assign a_hi       = a[WORD_BITS-1:H];
    assign b_hi       = b[WORD_BITS-1:H];
    assign ll_next    = (2*H)'(a_lo) * (2*H)'(b_lo);
    assign lh_prod    = WORD_BITS'(a_lo) * WORD_BITS'(b_hi);
    assign hl_prod    = WORD_BITS'(a_hi) * WORD_BITS'(b_lo);
    assign cross_next = lh_prod[L-1:0] + hl_prod[L-1:0];
    assign sum_next   = (op == ALU_SUB) ? (a - b) : (a + b);

    always_comb
    begin
        if (op_reg == ALU_MUL)
        begin
            result_next = ll_reg[WORD_BITS-1:0] + {cross_reg, {H{1'b0}}};
        end
        else
        begin
            result_next = sum_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op;
        sum_reg    <= sum_next;
        ll_reg     <= ll_next;
        cross_reg  <= cross_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ===== design/indexed_vector_store.sv =====
// Top level of the indexed vector store: controller, cell chain and arithmetic unit.
//
// A bounded vector of up to DEPTH signed words held in a chain of cells, one word per cell.
// Append, insert, remove, read, clear and increment or decrement of all elements: the item
// is taken and its single result is ready in the output register on the next cycle. Add,
// subtract or multiply at an index steps through reading the cell, two stages of the shared
// arithmetic unit and the write back. The emit operations give one result per element through
// the same arithmetic unit: each element is read and passes the two arithmetic stages, and its
// result is loaded once the output side is free, so the input is held through all elements
// and any output stalls. A new item is taken only once the previous one has finished.
module indexed_vector_store #(
    parameter int DEPTH     = ivs_pkg::DEPTH_DEF,
    parameter int WORD_BITS = ivs_pkg::WORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // index[5:0], operand[37:6], zero pad
    input  logic [3:0]  s_tuser,   // opcode[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // element[31:0], position[36:32], count[42:37], zero pad
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // status[1:0]
);
    import ivs_pkg::*;

    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (LEN_W > IDX_W) ? LEN_W : IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [ADDR_W-1:0]    rd_addr_reg;
    logic [WORD_BITS-1:0] opd_reg;
    alu_op_t              alu_op_reg;
    logic                 emit_reg;

    logic                 out_valid_reg;
    logic [31:0]          out_elem_reg;
    logic [4:0]           out_pos_reg;
    logic                 out_last_reg;
    status_t              out_status_reg;
    logic [5:0]           out_count_reg;

    logic [IDX_W-1:0]     in_index;
    logic [31:0]          in_operand;
    logic [WORD_BITS-1:0] opd_w;
    logic                 out_free;
    logic                 out_load;
    logic                 accept;
    logic [CMP_W-1:0]     idx_x;
    logic [CMP_W-1:0]     len_x;
    logic                 full;
    logic                 empty;
    logic                 in_range;
    logic [ADDR_W-1:0]    rd_sel;
    logic [WORD_BITS-1:0] rd_word;
    logic                 emit_last;
    logic [WORD_BITS-1:0] alu_result;

    cell_cmd_t            dec_cmd;
    cell_cmd_t            cell_cmd;
    logic [WORD_BITS-1:0] cell_data;
    status_t              dec_status;
    logic [31:0]          dec_elem;
    logic [4:0]           dec_pos;
    logic [LEN_W-1:0]     len_next;
    logic                 dec_alu;
    logic                 dec_emit;
    alu_op_t              dec_alu_op;

    logic [WORD_BITS-1:0] cell_word [DEPTH];

    assign in_index   = s_tdata[5:0];
    assign in_operand = s_tdata[37:6];
    assign opd_w      = WORD_BITS'($signed(in_operand));

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign out_load = (accept && !dec_alu) || ((state_reg == S_DONE) && out_free);

    assign idx_x    = CMP_W'(in_index);
    assign len_x    = CMP_W'(len_reg);
    assign full     = len_x >= CMP_W'(DEPTH);
    assign empty    = len_reg == '0;
    assign in_range = idx_x < len_x;

    assign rd_sel    = (state_reg != S_IDLE) ? rd_addr_reg
                     : (in_range ? in_index[ADDR_W-1:0] : '0);
    assign rd_word   = cell_word[rd_sel];
    assign emit_last = (CMP_W'(rd_addr_reg) + CMP_W'(1)) == len_x;

    always_comb
    begin
        dec_cmd.op   = CELL_HOLD;
        dec_cmd.addr = '0;
        dec_status   = STS_OK;
        dec_elem     = '0;
        dec_pos      = '0;
        len_next     = len_reg;
        dec_alu      = 1'b0;
        dec_emit     = 1'b0;
        dec_alu_op   = ALU_ADD;
        unique case (opcode_t'(s_tuser))
            OP_APPEND:
            begin
                if (full)
                begin
                    dec_status = STS_FULL;
                end
                else
                begin
                    dec_cmd.op   = CELL_LOAD;
                    dec_cmd.addr = IDX_W'(len_reg);
                    len_next     = len_reg + LEN_W'(1);
                end
            end
            OP_INSERT:
            begin
                if (idx_x > len_x)
                begin
                    dec_status = STS_RANGE;
                end
                else if (full)
                begin
                    dec_status = STS_FULL;
                end
                else
                begin
                    dec_cmd.op   = CELL_SHIFT_UP;
                    dec_cmd.addr = in_index;
                    len_next     = len_reg + LEN_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (empty)
                begin
                    dec_status = STS_EMPTY;
                end
                else if (!in_range)
                begin
                    dec_status = STS_RANGE;
                end
                else
                begin
                    dec_cmd.op   = CELL_SHIFT_DOWN;
                    dec_cmd.addr = in_index;
                    len_next     = len_reg - LEN_W'(1);
                end
            end
            OP_READ:
            begin
                if (empty)
                begin
                    dec_status = STS_EMPTY;
                end
                else
                begin
                    dec_elem = 32'($signed(rd_word));
                    if (in_range)
                    begin
                        dec_pos = in_index[4:0];
                    end
                    else
                    begin
                        dec_status = STS_RANGE;
                    end
                end
            end
            OP_CLEAR:
            begin
                len_next = '0;
            end
            OP_INC_ALL, OP_DEC_ALL:
            begin
                if (empty)
                begin
                    dec_status = STS_EMPTY;
                end
                else
                begin
                    dec_cmd.op = (opcode_t'(s_tuser) == OP_INC_ALL) ? CELL_INC : CELL_DEC;
                end
            end
            OP_EMIT_ADD, OP_EMIT_SUB, OP_EMIT_MUL:
            begin
                if (empty)
                begin
                    dec_status = STS_EMPTY;
                end
                else
                begin
                    dec_alu  = 1'b1;
                    dec_emit = 1'b1;
                    priority if (opcode_t'(s_tuser) == OP_EMIT_ADD)
                    begin
                        dec_alu_op = ALU_ADD;
                    end
                    else if (opcode_t'(s_tuser) == OP_EMIT_SUB)
                    begin
                        dec_alu_op = ALU_SUB;
                    end
                    else
                    begin
                        dec_alu_op = ALU_MUL;
                    end
                end
            end
            OP_ADD_AT, OP_SUB_AT, OP_MUL_AT:
            begin
                if (empty)
                begin
                    dec_status = STS_EMPTY;
                end
                else if (!in_range)
                begin
                    dec_status = STS_RANGE;
                end
                else
                begin
                    dec_alu = 1'b1;
                    priority if (opcode_t'(s_tuser) == OP_ADD_AT)
                    begin
                        dec_alu_op = ALU_ADD;
                    end
                    else if (opcode_t'(s_tuser) == OP_SUB_AT)
                    begin
                        dec_alu_op = ALU_SUB;
                    end
                    else
                    begin
                        dec_alu_op = ALU_MUL;
                    end
                end
            end
            default:
            begin
                dec_status = STS_OK;
            end
        endcase
    end

    always_comb
    begin
        cell_cmd.op   = CELL_HOLD;
        cell_cmd.addr = '0;
        cell_data     = opd_w;
        priority if (accept)
        begin
            cell_cmd = dec_cmd;
        end
        else if ((state_reg == S_DONE) && out_free && !emit_reg)
        begin
            cell_cmd.op   = CELL_LOAD;
            cell_cmd.addr = IDX_W'(rd_addr_reg);
            cell_data     = alu_result;
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;

        ivs_cell #(
            .WORD_BITS (WORD_BITS),
            .POS       (g)
        ) u_cell (
            .clk       (clk),
            .cmd       (cell_cmd),
            .data      (cell_data),
            .prev_word (cell_word[PREV]),
            .next_word (cell_word[NEXT]),
            .word      (cell_word[g])
        );
    end

    ivs_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .clk    (clk),
        .op     (alu_op_reg),
        .a      (rd_word),
        .b      (opd_reg),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            rd_addr_reg    <= '0;
            opd_reg        <= '0;
            alu_op_reg     <= ALU_ADD;
            emit_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_elem_reg   <= '0;
            out_pos_reg    <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= STS_OK;
            out_count_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        len_reg <= len_next;
                        if (dec_alu)
                        begin
                            state_reg   <= S_READ;
                            rd_addr_reg <= dec_emit ? '0 : in_index[ADDR_W-1:0];
                            opd_reg     <= opd_w;
                            alu_op_reg  <= dec_alu_op;
                            emit_reg    <= dec_emit;
                        end
                        else
                        begin
                            out_valid_reg  <= 1'b1;
                            out_elem_reg   <= dec_elem;
                            out_pos_reg    <= dec_pos;
                            out_last_reg   <= 1'b1;
                            out_status_reg <= dec_status;
                            out_count_reg  <= 6'(len_next);
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= STS_OK;
                        out_count_reg  <= 6'(len_reg);
                        if (emit_reg)
                        begin
                            out_elem_reg <= 32'($signed(alu_result));
                            out_pos_reg  <= 5'(rd_addr_reg);
                            out_last_reg <= emit_last;
                            if (emit_last)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                                state_reg   <= S_READ;
                            end
                        end
                        else
                        begin
                            out_elem_reg <= '0;
                            out_pos_reg  <= '0;
                            out_last_reg <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_count_reg, out_pos_reg, out_elem_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ===== dv/vector_store_checker.sv =====
`timescale 1ns / 1ps
// Checker for the indexed vector store: tracks the vector from accepted items and checks every result.
module vector_store_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // index[5:0], operand[37:6], zero pad
    input  logic [3:0]  s_tuser,   // opcode[3:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // element[31:0], position[36:32], count[42:37], zero pad
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,   // status[1:0]
    output int          errors,
    output int          pending,
    output int          results_seen,
    output int          peak_length
);
    import ivs_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    typedef struct packed {
        logic [31:0] element;
        logic [4:0]  position;
        logic        last;
        status_t     status;
        logic [5:0]  count;
    } vec_result_t;

    logic [31:0] store_words [DEPTH];
    int          store_len;
    vec_result_t expected_q [$];
    int          error_tally;
    int          result_tally;
    int          peak_tally;

    function automatic void push_result(input logic [31:0] elem, input int pos,
                                        input logic last, input status_t sts);
        vec_result_t r;
        r.element  = elem;
        r.position = pos[4:0];
        r.last     = last;
        r.status   = sts;
        r.count    = store_len[5:0];
        expected_q.push_back(r);
    endfunction

    function automatic void apply_item(input logic [3:0] op, input int idx,
                                       input logic [31:0] opd);
        logic [31:0] word;
        case (op)
            OP_APPEND:
            begin
                if (store_len >= DEPTH)
                    push_result('0, 0, 1'b1, STS_FULL);
                else
                begin
                    store_words[store_len] = opd;
                    store_len++;
                    push_result('0, 0, 1'b1, STS_OK);
                end
            end
            OP_INSERT:
            begin
                if (idx > store_len)
                    push_result('0, 0, 1'b1, STS_RANGE);
                else if (store_len >= DEPTH)
                    push_result('0, 0, 1'b1, STS_FULL);
                else
                begin
                    for (int i = store_len; i > idx; i--)
                        store_words[i] = store_words[i-1];
                    store_words[idx] = opd;
                    store_len++;
                    push_result('0, 0, 1'b1, STS_OK);
                end
            end
            OP_REMOVE:
            begin
                if (store_len == 0)
                    push_result('0, 0, 1'b1, STS_EMPTY);
                else if (idx >= store_len)
                    push_result('0, 0, 1'b1, STS_RANGE);
                else
                begin
                    for (int i = idx; i + 1 < store_len; i++)
                        store_words[i] = store_words[i+1];
                    store_len--;
                    push_result('0, 0, 1'b1, STS_OK);
                end
            end
            OP_READ:
            begin
                if (store_len == 0)
                    push_result('0, 0, 1'b1, STS_EMPTY);
                else if (idx >= store_len)
                    push_result(store_words[0], 0, 1'b1, STS_RANGE);
                else
                    push_result(store_words[idx], idx, 1'b1, STS_OK);
            end
            OP_CLEAR:
            begin
                store_len = 0;
                push_result('0, 0, 1'b1, STS_OK);
            end
            OP_INC_ALL, OP_DEC_ALL:
            begin
                if (store_len == 0)
                    push_result('0, 0, 1'b1, STS_EMPTY);
                else
                begin
                    for (int i = 0; i < store_len; i++)
                        store_words[i] = (op == OP_INC_ALL) ? store_words[i] + 32'd1
                                                            : store_words[i] - 32'd1;
                    push_result('0, 0, 1'b1, STS_OK);
                end
            end
            OP_EMIT_ADD, OP_EMIT_SUB, OP_EMIT_MUL:
            begin
                if (store_len == 0)
                    push_result('0, 0, 1'b1, STS_EMPTY);
                else
                begin
                    for (int i = 0; i < store_len; i++)
                    begin
                        if (op == OP_EMIT_ADD)
                            word = store_words[i] + opd;
                        else if (op == OP_EMIT_SUB)
                            word = store_words[i] - opd;
                        else
                            word = store_words[i] * opd;
                        push_result(word, i, i + 1 == store_len, STS_OK);
                    end
                end
            end
            OP_ADD_AT, OP_SUB_AT, OP_MUL_AT:
            begin
                if (store_len == 0)
                    push_result('0, 0, 1'b1, STS_EMPTY);
                else if (idx >= store_len)
                    push_result('0, 0, 1'b1, STS_RANGE);
                else
                begin
                    if (op == OP_ADD_AT)
                        store_words[idx] = store_words[idx] + opd;
                    else if (op == OP_SUB_AT)
                        store_words[idx] = store_words[idx] - opd;
                    else
                        store_words[idx] = store_words[idx] * opd;
                    push_result('0, 0, 1'b1, STS_OK);
                end
            end
            default:
                push_result('0, 0, 1'b1, STS_OK);
        endcase
        if (store_len > peak_tally)
            peak_tally = store_len;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        vec_result_t want;
        if (!rst_n)
        begin
            store_len    = 0;
            error_tally  = 0;
            result_tally = 0;
            peak_tally   = 0;
            expected_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_item(s_tuser, int'(s_tdata[5:0]), s_tdata[37:6]);
            if (m_tvalid && m_tready)
            begin
                result_tally++;
                if (expected_q.size() == 0)
                begin
                    $error("result at position %0d arrived with no item pending",
                           m_tdata[36:32]);
                    error_tally++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tdata[31:0] !== want.element)
                    begin
                        $error("element: expected %0d, got %0d",
                               $signed(want.element), $signed(m_tdata[31:0]));
                        error_tally++;
                    end
                    if (m_tdata[36:32] !== want.position)
                    begin
                        $error("position: expected %0d, got %0d",
                               want.position, m_tdata[36:32]);
                        error_tally++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        error_tally++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        error_tally++;
                    end
                    if (m_tdata[42:37] !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, m_tdata[42:37]);
                        error_tally++;
                    end
                end
            end
        end
        errors       <= error_tally;
        pending      <= expected_q.size();
        results_seen <= result_tally;
        peak_length  <= peak_tally;
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the indexed vector store: clock, reset, item stimulus, output pacing and verdict.
module tb_top;
    import ivs_pkg::*;

    localparam logic [3:0] OP_SPARE_LO   = 4'd13;
    localparam logic [3:0] OP_SPARE_HI   = 4'd15;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         MIXED_ITEMS   = 35;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    int   errors;
    int   pending;
    int   results_seen;
    int   peak_length;
    int   items_sent     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;
    logic hold_req       = 1'b0;
    logic hold_done      = 1'b0;

    int send_pct_by_phase [4] = '{0, 49, 0, 17};
    int recv_pct_by_phase [4] = '{0, 0, 49, 17};

    indexed_vector_store i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    vector_store_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .peak_length  (peak_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no item moved for %0d cycles, %0d results still due",
                         STALL_LIMIT, pending);
                $display("DONE: errors detected");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return 32'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [3:0] pick_opcode();
        logic [3:0] op;
        op = 4'($urandom_range(0, 12));
        if (op == OP_CLEAR && $urandom_range(0, 3) != 0)
            op = OP_APPEND;
        if ($urandom_range(0, 99) == 0)
            op = OP_SPARE_HI;
        return op;
    endfunction

    task automatic send_item(input logic [3:0] op, input logic [5:0] idx,
                             input logic [31:0] opd);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, opd, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        int fill_n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_REMOVE, 6'd0, 32'd5);
        send_item(OP_READ, 6'd0, 32'd0);
        send_item(OP_INC_ALL, 6'd0, 32'd0);
        send_item(OP_EMIT_ADD, 6'd0, 32'd1);
        send_item(OP_ADD_AT, 6'd0, 32'd1);
        send_item(OP_INSERT, 6'd1, 32'd9);
        send_item(OP_APPEND, 6'd0, 32'h7FFF_FFFF);
        send_item(OP_APPEND, 6'd63, 32'h8000_0000);
        send_item(OP_INSERT, 6'd0, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 6'd3, 32'd0);
        send_item(OP_INC_ALL, 6'd0, 32'd0);
        send_item(OP_DEC_ALL, 6'd0, 32'd0);
        send_item(OP_READ, 6'd32, 32'd0);
        send_item(OP_READ, 6'd2, 32'd0);
        send_item(OP_ADD_AT, 6'd1, 32'h7FFF_FFFF);
        send_item(OP_SUB_AT, 6'd0, 32'h8000_0000);
        send_item(OP_MUL_AT, 6'd2, 32'hFFFF_FFFF);
        send_item(OP_MUL_AT, 6'd32, 32'd3);
        send_item(OP_REMOVE, 6'd4, 32'd0);
        send_item(OP_EMIT_ADD, 6'd0, 32'h7FFF_FFFF);
        send_item(OP_EMIT_SUB, 6'd0, 32'h8000_0000);
        send_item(OP_EMIT_MUL, 6'd0, 32'hFFFF_FFFF);
        send_item(OP_SPARE_LO, 6'd0, 32'd0);
        send_item(OP_SPARE_HI, 6'd31, 32'hFFFF_FFFF);
        send_item(OP_REMOVE, 6'd0, 32'd0);
        send_item(OP_CLEAR, 6'd0, 32'd0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = send_pct_by_phase[ph];
            recv_stall_pct <= recv_pct_by_phase[ph];
            send_item(OP_CLEAR, 6'($urandom_range(0, 32)), pick_operand());
            fill_n = $urandom_range(20, 34);
            for (int k = 0; k < fill_n; k++)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_item(OP_INSERT, 6'($urandom_range(0, k > 32 ? 32 : k)),
                              pick_operand());
                else
                    send_item(OP_APPEND, 6'($urandom_range(0, 32)), pick_operand());
            end
            if (ph == 0)
                hold_req <= 1'b1;
            for (int k = 0; k < MIXED_ITEMS; k++)
                send_item(pick_opcode(), 6'($urandom_range(0, 32)), pick_operand());
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d items and %0d checked results over four idling phases,",
                 items_sent, results_seen);
        $display("with a vector length peaking at %0d and one long output hold-off.",
                 peak_length);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
